// ===== sv/grba_pkg.sv =====
// Shared types and constants of the gyro rate block averager.
package grba_pkg;

	// Defaults for the top-level parameters
	localparam int ADC_BITS_DEF   = 16;
	localparam int MAX_WINDOW_DEF = 64;

	// Fixed field widths
	localparam int SAMPLE_W  = 16;
	localparam int LEN_REG_W = 7;
	localparam int OFFSET_W  = 16;
	localparam int SCALE_W   = 20;
	localparam int RATE_W    = 28;

	// Configuration port
	localparam int REG_IDX_W = 3;
	localparam int CFG_DATA_W = 20;

	localparam logic [REG_IDX_W-1:0] REG_AVG_EN   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WIN_LEN  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_X_OFFSET = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_X_SCALE  = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_Y_SCALE  = 3'd5;

	// Final divide: micro to milli
	localparam int DIVISOR_K = 1000;
	localparam int K_W       = $clog2(DIVISOR_K);

	typedef struct packed {
		logic [SAMPLE_W-1:0] x_sample;
		logic                x_valid;
		logic [SAMPLE_W-1:0] y_sample;
		logic                y_valid;
	} in_item_t;

	typedef struct packed {
		logic signed [RATE_W-1:0] x_rate;
		logic                     x_present;
		logic signed [RATE_W-1:0] y_rate;
		logic                     y_present;
	} out_item_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0]  reg_index;
		logic [CFG_DATA_W-1:0] wdata;
	} cfg_item_t;

	// Command from the top level to an axis lane
	typedef struct packed {
		logic start;   // take value and begin
		logic divide;  // divide value by the window length first
		logic ack;     // result taken, lane may return to idle
	} lane_cmd_t;

endpackage

// ===== sv/grba_chan_if.sv =====
// Valid/ready channel carrying one item of a given type.
interface grba_chan_if #(
	parameter type item_t = logic
) ();
	logic  valid;
	logic  ready;
	item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// ===== sv/grba_axis.sv =====
// One axis lane: bit-serial length divide, offset subtract, serial multiply, divide by 1000.
module grba_axis #(
	parameter int VAL_W = 22,
	parameter int LEN_W = 7
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  grba_pkg::lane_cmd_t               cmd,
	input  logic [VAL_W-1:0]                  value,
	input  logic [LEN_W-1:0]                  len,
	input  logic [grba_pkg::OFFSET_W-1:0]     offset,
	input  logic [grba_pkg::SCALE_W-1:0]      scale,
	output logic                              done,
	output logic signed [grba_pkg::RATE_W-1:0] rate
);
	import grba_pkg::*;

	localparam int DW    = (VAL_W > OFFSET_W) ? VAL_W : OFFSET_W;
	localparam int PW    = DW + SCALE_W;
	localparam int CNT_W = $clog2(PW + 1);
	localparam logic [K_W:0] K_EXT = (K_W + 1)'(DIVISOR_K);

	localparam logic [2:0] PH_IDLE = 3'd0;
	localparam logic [2:0] PH_DIVL = 3'd1;
	localparam logic [2:0] PH_SUB  = 3'd2;
	localparam logic [2:0] PH_MUL  = 3'd3;
	localparam logic [2:0] PH_DIVK = 3'd4;
	localparam logic [2:0] PH_DONE = 3'd5;

	logic [2:0]         phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [VAL_W-1:0]   q_q;
	logic [LEN_W-1:0]   rem_q;
	logic [DW-1:0]      mag_q;
	logic               neg_q;
	logic [SCALE_W-1:0] sc_q;
	logic [PW-1:0]      prod_q;
	logic [K_W-1:0]     remk_q;

	logic [LEN_W:0]     dl_t, dl_sub;
	logic               dl_ge;
	logic [DW:0]        diff, diff_neg;
	logic [K_W:0]       dk_t, dk_sub;
	logic               dk_ge;
	logic [RATE_W-1:0]  rate_mag;

	always_comb begin
		dl_t     = {rem_q, q_q[VAL_W-1]};
		dl_sub   = dl_t - {1'b0, len};
		dl_ge    = dl_t >= {1'b0, len};
		diff     = {1'b0, DW'(q_q)} - {1'b0, DW'(offset)};
		diff_neg = -diff;
		dk_t     = {remk_q, prod_q[PW-1]};
		dk_sub   = dk_t - K_EXT;
		dk_ge    = dk_t >= K_EXT;
		rate_mag = prod_q[RATE_W-1:0];
	end

	assign done = (phase_q == PH_DONE);
	assign rate = neg_q ? -rate_mag : rate_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (cmd.start) begin
						cnt_q   <= '0;
						phase_q <= cmd.divide ? PH_DIVL : PH_SUB;
					end
				end
				PH_DIVL: begin
					if (cnt_q == CNT_W'(VAL_W - 1)) begin
						cnt_q   <= '0;
						phase_q <= PH_SUB;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_SUB: begin
					phase_q <= PH_MUL;
				end
				PH_MUL: begin
					if (cnt_q == CNT_W'(SCALE_W - 1)) begin
						cnt_q   <= '0;
						phase_q <= PH_DIVK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_DIVK: begin
					if (cnt_q == CNT_W'(PW - 1)) begin
						cnt_q   <= '0;
						phase_q <= PH_DONE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				PH_DONE: begin
					if (cmd.ack) begin
						phase_q <= PH_IDLE;
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				q_q   <= value;
				rem_q <= '0;
			end
			PH_DIVL: begin
				// restoring divide, one quotient bit a cycle
				rem_q <= dl_ge ? dl_sub[LEN_W-1:0] : dl_t[LEN_W-1:0];
				q_q   <= {q_q[VAL_W-2:0], dl_ge};
			end
			PH_SUB: begin
				neg_q  <= diff[DW];
				mag_q  <= diff[DW] ? diff_neg[DW-1:0] : diff[DW-1:0];
				sc_q   <= scale;
				prod_q <= '0;
				remk_q <= '0;
			end
			PH_MUL: begin
				// MSB-first shift and add
				prod_q <= {prod_q[PW-2:0], 1'b0} + (sc_q[SCALE_W-1] ? PW'(mag_q) : '0);
				sc_q   <= {sc_q[SCALE_W-2:0], 1'b0};
			end
			PH_DIVK: begin
				remk_q <= dk_ge ? dk_sub[K_W-1:0] : dk_t[K_W-1:0];
				prod_q <= {prod_q[PW-2:0], dk_ge};
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== sv/gyro_rate_block_averager_core.sv =====
// Top level of the two-axis gyro rate block averager.
//
// Takes one X/Y pair of raw ADC counts per input item, each with a valid
// flag, and gives angular rates in milliradians per second. With averaging
// off every pair gives one result; with averaging on both axes are summed
// over window_length pairs and one result leaves per full window, from the
// truncated mean. Each axis then has its zero offset subtracted, is
// multiplied by its scale and divided by 1000, truncating toward zero. An
// axis is present only if every sample of its window (or the single sample)
// was valid; a missing axis reports a rate of 0. A pair that does not close
// a window only updates the window state. A pair that gives a result runs
// through two bit-serial axis lanes side by side: an optional restoring
// divide of the ACC_W-bit value by the window length (ACC_W = min(ADC_BITS,16)
// + log2(MAX_WINDOW)), offset subtraction, a shift-add multiply by the 20-bit
// scale and a divide by 1000 of the PW-bit product (PW = max(ACC_W,16) + 20),
// plus a handover to the output register. The next item is taken as soon as
// the lanes have handed their result to the output register, even while that
// result still waits to be taken. Configuration registers are written
// through the cfg channel, which is always ready; writes to unused indexes
// are dropped.
module gyro_rate_block_averager_core #(
	parameter int ADC_BITS   = grba_pkg::ADC_BITS_DEF,
	parameter int MAX_WINDOW = grba_pkg::MAX_WINDOW_DEF
) (
	input logic         clk,
	input logic         arst_n,
	grba_chan_if.sink   in_ch,
	grba_chan_if.source out_ch,
	grba_chan_if.sink   cfg_ch
);
	import grba_pkg::*;

	// sample bits kept, window sum and length widths
	localparam int SW    = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
	localparam int ACC_W = SW + $clog2(MAX_WINDOW);
	localparam int LEN_W = $clog2(MAX_WINDOW + 1);

	// configuration registers
	logic                 avg_en_q;
	logic [LEN_REG_W-1:0] win_len_q;
	logic [OFFSET_W-1:0]  x_offset_q, y_offset_q;
	logic [SCALE_W-1:0]   x_scale_q, y_scale_q;

	// window state
	logic [ACC_W-1:0] x_acc_q, y_acc_q;
	logic [LEN_W-1:0] fill_q;
	logic             x_ok_q, y_ok_q;

	// control
	logic      busy_q;
	logic      x_pres_q, y_pres_q;
	logic      out_valid_q;
	out_item_t out_item_q;

	logic             in_acc, cfg_acc;
	logic [LEN_W-1:0] len_eff, fill_n;
	logic [ACC_W-1:0] x_sum_n, y_sum_n, x_val, y_val;
	logic             x_ok_n, y_ok_n, closes, produce, handover;
	logic             x_done, y_done;
	logic signed [RATE_W-1:0] x_rate_l, y_rate_l;
	lane_cmd_t        cmd;
	in_item_t         it;

	assign it      = in_ch.item;
	assign in_acc  = in_ch.valid && in_ch.ready;
	assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

	assign in_ch.ready  = !busy_q;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign out_ch.item  = out_item_q;

	// Effective window length: zero counts as one, long windows are clipped
	always_comb begin
		if (win_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(win_len_q) > 32'(MAX_WINDOW)) begin
			len_eff = LEN_W'(MAX_WINDOW);
		end else begin
			len_eff = LEN_W'(win_len_q);
		end
	end

	// Next window state for the item on the input
	always_comb begin
		x_sum_n = x_acc_q + (it.x_valid ? ACC_W'(it.x_sample[SW-1:0]) : '0);
		y_sum_n = y_acc_q + (it.y_valid ? ACC_W'(it.y_sample[SW-1:0]) : '0);
		x_ok_n  = x_ok_q && it.x_valid;
		y_ok_n  = y_ok_q && it.y_valid;
		fill_n  = fill_q + 1'b1;
		closes  = fill_n >= len_eff;
		produce = !avg_en_q || closes;
		x_val   = avg_en_q ? x_sum_n : ACC_W'(it.x_sample[SW-1:0]);
		y_val   = avg_en_q ? y_sum_n : ACC_W'(it.y_sample[SW-1:0]);
	end

	// Lanes finish together; hand over once the output register is free
	assign handover = busy_q && x_done && y_done && (!out_valid_q || out_ch.ready);

	always_comb begin
		cmd.start  = in_acc && produce;
		cmd.divide = avg_en_q;
		cmd.ack    = handover;
	end

	grba_axis #(.VAL_W(ACC_W), .LEN_W(LEN_W)) u_x_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (x_val),
		.len    (len_eff),
		.offset (x_offset_q),
		.scale  (x_scale_q),
		.done   (x_done),
		.rate   (x_rate_l)
	);

	grba_axis #(.VAL_W(ACC_W), .LEN_W(LEN_W)) u_y_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.value  (y_val),
		.len    (len_eff),
		.offset (y_offset_q),
		.scale  (y_scale_q),
		.done   (y_done),
		.rate   (y_rate_l)
	);

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_en_q   <= 1'b0;
			win_len_q  <= LEN_REG_W'(1);
			x_offset_q <= '0;
			y_offset_q <= '0;
			x_scale_q  <= '0;
			y_scale_q  <= '0;
		end else if (cfg_acc) begin
			case (cfg_ch.item.reg_index)
				REG_AVG_EN:   avg_en_q   <= cfg_ch.item.wdata[0];
				REG_WIN_LEN:  win_len_q  <= cfg_ch.item.wdata[LEN_REG_W-1:0];
				REG_X_OFFSET: x_offset_q <= cfg_ch.item.wdata[OFFSET_W-1:0];
				REG_Y_OFFSET: y_offset_q <= cfg_ch.item.wdata[OFFSET_W-1:0];
				REG_X_SCALE:  x_scale_q  <= cfg_ch.item.wdata[SCALE_W-1:0];
				REG_Y_SCALE:  y_scale_q  <= cfg_ch.item.wdata[SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Window accumulation; left alone while averaging is off
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_acc_q <= '0;
			y_acc_q <= '0;
			fill_q  <= '0;
			x_ok_q  <= 1'b1;
			y_ok_q  <= 1'b1;
		end else if (in_acc && avg_en_q) begin
			if (closes) begin
				x_acc_q <= '0;
				y_acc_q <= '0;
				fill_q  <= '0;
				x_ok_q  <= 1'b1;
				y_ok_q  <= 1'b1;
			end else begin
				x_acc_q <= x_sum_n;
				y_acc_q <= y_sum_n;
				fill_q  <= fill_n;
				x_ok_q  <= x_ok_n;
				y_ok_q  <= y_ok_n;
			end
		end
	end

	// Item in flight and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			x_pres_q    <= 1'b0;
			y_pres_q    <= 1'b0;
		end else begin
			if (cmd.start) begin
				busy_q   <= 1'b1;
				x_pres_q <= avg_en_q ? x_ok_n : it.x_valid;
				y_pres_q <= avg_en_q ? y_ok_n : it.y_valid;
			end else if (handover) begin
				busy_q <= 1'b0;
			end
			if (handover) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (handover) begin
			out_item_q.x_rate    <= x_pres_q ? x_rate_l : '0;
			out_item_q.x_present <= x_pres_q;
			out_item_q.y_rate    <= y_pres_q ? y_rate_l : '0;
			out_item_q.y_present <= y_pres_q;
		end
	end

endmodule
